// File: design/nfsa_pkg.sv
// Shared constants, codes and types of the nested frame slot allocator.
package nfsa_pkg;

	// Table size and derived index widths
	localparam int SLOT_COUNT = 16;
	localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
	localparam int TREE_N     = 1 << IDX_W;

	// Field widths
	localparam int FUNC_W   = 3;
	localparam int ID_W     = 32;
	localparam int HANDLE_W = 31;
	localparam int HIDX_W   = 5;
	localparam int GEN_W    = 26;
	localparam int LVL_W    = 5;
	localparam int ADDR_W   = 32;
	localparam int STRIDE_W = 17;
	localparam int OFS_W    = 16;
	localparam int TOTAL_W  = 32;
	localparam int OCNT_W   = 5;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration port
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;
	localparam int RSEL_W  = 3;

	localparam logic [RSEL_W-1:0] REG_REGION_BASE   = 3'd0;
	localparam logic [RSEL_W-1:0] REG_SLOT_STRIDE   = 3'd1;
	localparam logic [RSEL_W-1:0] REG_STACK_OFFSET  = 3'd2;
	localparam logic [RSEL_W-1:0] REG_GUARD_BYTES   = 3'd3;
	localparam logic [RSEL_W-1:0] REG_DEPTH_LIMIT   = 3'd4;
	localparam logic [RSEL_W-1:0] REG_REGION_ENABLE = 3'd5;

	localparam logic [ADDR_W-1:0]   RST_REGION_BASE  = 32'd0;
	localparam logic [STRIDE_W-1:0] RST_SLOT_STRIDE  = 17'd4096;
	localparam logic [OFS_W-1:0]    RST_STACK_OFFSET = 16'd3072;
	localparam logic [OFS_W-1:0]    RST_GUARD_BYTES  = 16'd256;
	localparam logic [LVL_W-1:0]    RST_DEPTH_LIMIT  = 5'd4;

	// Function codes on the request channel
	localparam logic [FUNC_W-1:0] FUNC_ACQUIRE       = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_RELEASE       = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_RELEASE_OWNER = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_RELEASE_ALL   = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_DEPTH_QUERY   = 3'd4;
	localparam logic [FUNC_W-1:0] FUNC_HANDLE_INFO   = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR         = 3'd6;

	typedef enum logic [2:0] {
		OP_ACQUIRE,
		OP_RELEASE,
		OP_RELEASE_OWNER,
		OP_RELEASE_ALL,
		OP_DEPTH_QUERY,
		OP_HANDLE_INFO,
		OP_CLEAR,
		OP_NONE
	} op_t;

	// Classified request as it waits in the queue
	typedef struct packed {
		op_t              op;
		logic [ID_W-1:0]  owner_id;
		logic             idx_ok;
		logic [IDX_W-1:0] idx;
		logic [GEN_W-1:0] gen;
	} q_entry_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   region_base;
		logic [STRIDE_W-1:0] slot_stride;
		logic [OFS_W-1:0]    stack_offset;
		logic [OFS_W-1:0]    guard_bytes;
		logic [LVL_W-1:0]    depth_limit;
		logic                region_enable;
	} cfg_t;

	typedef struct packed {
		logic                ok;
		logic [HANDLE_W-1:0] frame_handle;
		logic [ADDR_W-1:0]   frame_sp;
		logic [ID_W-1:0]     frame_owner;
		logic [LVL_W-1:0]    frame_depth;
		logic [ADDR_W-1:0]   frame_base;
		logic [ADDR_W-1:0]   frame_floor;
		logic [OCNT_W-1:0]   freed_count;
		logic                lifo_flag;
		logic [OCNT_W-1:0]   live_count;
		logic [TOTAL_W-1:0]  exhaust_total;
		logic [TOTAL_W-1:0]  lifo_total;
	} rsp_t;

	typedef enum logic {
		BK_IDLE,
		BK_COMMIT
	} bk_state_t;

endpackage

// File: design/nfsa_ifs.sv
// Request and response channel interfaces of the frame slot allocator.
interface nfsa_req_if import nfsa_pkg::*;;
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [ID_W-1:0]     owner_id;
	logic [HANDLE_W-1:0] handle_in;

	modport source(output valid, func, owner_id, handle_in, input ready);
	modport sink(input valid, func, owner_id, handle_in, output ready);
endinterface

interface nfsa_rsp_if import nfsa_pkg::*;;
	logic                valid;
	logic                ready;
	logic                ok;
	logic [HANDLE_W-1:0] frame_handle;
	logic [ADDR_W-1:0]   frame_sp;
	logic [ID_W-1:0]     frame_owner;
	logic [LVL_W-1:0]    frame_depth;
	logic [ADDR_W-1:0]   frame_base;
	logic [ADDR_W-1:0]   frame_floor;
	logic [OCNT_W-1:0]   freed_count;
	logic                lifo_flag;
	logic [OCNT_W-1:0]   live_count;
	logic [TOTAL_W-1:0]  exhaust_total;
	logic [TOTAL_W-1:0]  lifo_total;

	modport source(output valid, ok, frame_handle, frame_sp, frame_owner, frame_depth,
		frame_base, frame_floor, freed_count, lifo_flag, live_count, exhaust_total,
		lifo_total, input ready);
	modport sink(input valid, ok, frame_handle, frame_sp, frame_owner, frame_depth,
		frame_base, frame_floor, freed_count, lifo_flag, live_count, exhaust_total,
		lifo_total, output ready);
endinterface

// File: design/nfsa_front.sv
// Front end: accepts requests, decodes the function and splits the handle.
module nfsa_front import nfsa_pkg::*; (
	nfsa_req_if.sink req,
	output logic     push_valid,
	input  logic     push_ready,
	output q_entry_t push_data
);

	logic [HIDX_W-1:0] hidx;

	// Accept whenever the queue has room
	assign req.ready  = push_ready;
	assign push_valid = req.valid;

	// Split the handle into slot index and generation
	assign hidx = req.handle_in[HIDX_W-1:0];

	always_comb begin
		push_data          = '0;
		push_data.owner_id = req.owner_id;
		push_data.idx      = req.handle_in[IDX_W-1:0];
		push_data.gen      = req.handle_in[HIDX_W +: GEN_W];
		push_data.idx_ok   = (hidx < HIDX_W'(SLOT_COUNT));
		case (req.func)
			FUNC_ACQUIRE:       push_data.op = OP_ACQUIRE;
			FUNC_RELEASE:       push_data.op = OP_RELEASE;
			FUNC_RELEASE_OWNER: push_data.op = OP_RELEASE_OWNER;
			FUNC_RELEASE_ALL:   push_data.op = OP_RELEASE_ALL;
			FUNC_DEPTH_QUERY:   push_data.op = OP_DEPTH_QUERY;
			FUNC_HANDLE_INFO:   push_data.op = OP_HANDLE_INFO;
			FUNC_CLEAR:         push_data.op = OP_CLEAR;
			default:            push_data.op = OP_NONE;
		endcase
	end

endmodule

// File: design/nfsa_queue.sv
// Short register queue between the front end and the back end.
module nfsa_queue import nfsa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  q_entry_t push_data,
	output logic     pop_valid,
	input  logic     pop_ready,
	output q_entry_t pop_data
);

	q_entry_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: design/nfsa_back.sv
// Back end: slot table, table scans, state update and response register.
module nfsa_back import nfsa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     pop_valid,
	output logic     pop_ready,
	input  q_entry_t pop_data,
	nfsa_rsp_if.source rsp
);

	// Slot table
	logic             slot_used_q  [SLOT_COUNT];
	logic [ID_W-1:0]  slot_owner_q [SLOT_COUNT];
	logic [LVL_W-1:0] slot_level_q [SLOT_COUNT];
	logic [GEN_W-1:0] slot_gen_q   [SLOT_COUNT];
	logic [CNT_W-1:0]   live_q;
	logic [TOTAL_W-1:0] exhaust_q;
	logic [TOTAL_W-1:0] lifo_q;

	// Scan stage
	q_entry_t            item_s1;
	logic [LVL_W-1:0]    deep_s1;
	logic                free_found_s1;
	logic [IDX_W-1:0]    free_idx_s1;
	logic                hit_s1;
	logic [SLOT_COUNT-1:0] mask_s1;
	logic [CNT_W-1:0]    freed_s1;

	bk_state_t state_q;
	bk_state_t state_d;
	logic      load_s1;
	logic      commit_en;

	rsp_t rsp_q;
	rsp_t rsp_d;
	logic rsp_valid_q;

	// Scan logic
	logic [ID_W-1:0]       key_owner;
	logic [SLOT_COUNT-1:0] match;
	logic [LVL_W-1:0]      tree [2*TREE_N-1];
	logic                  free_found_c;
	logic [IDX_W-1:0]      free_idx_c;
	logic                  hit_c;
	logic [SLOT_COUNT-1:0] mask_c;
	logic [CNT_W-1:0]      freed_c;

	// Commit logic
	logic             used_n  [SLOT_COUNT];
	logic [ID_W-1:0]  owner_n [SLOT_COUNT];
	logic [LVL_W-1:0] level_n [SLOT_COUNT];
	logic [GEN_W-1:0] gen_n   [SLOT_COUNT];
	logic [CNT_W-1:0]   live_n;
	logic [TOTAL_W-1:0] exhaust_n;
	logic [TOTAL_W-1:0] lifo_n;
	logic [IDX_W-1:0]   idx_c;
	logic [IDX_W+STRIDE_W-1:0] prod_c;
	logic [ADDR_W-1:0]  base_c;
	logic [LVL_W:0]     new_depth;
	logic               depth_fits;
	logic [GEN_W-1:0]   gen_inc;

	// Sequence one item: take it from the queue, then commit it
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE:   if (pop_valid) state_d = BK_COMMIT;
			BK_COMMIT: if (commit_en) state_d = BK_IDLE;
			default:   state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop_ready = 1'b0;
		commit_en = 1'b0;
		case (state_q)
			BK_IDLE:   pop_ready = 1'b1;
			BK_COMMIT: commit_en = !rsp_valid_q || rsp.ready;
			default:   pop_ready = 1'b0;
		endcase
	end

	assign load_s1 = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Owner compare against every slot; release looks at the owner of its own slot
	always_comb begin
		key_owner = (pop_data.op == OP_RELEASE) ? slot_owner_q[pop_data.idx]
			: pop_data.owner_id;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			match[i] = slot_used_q[i] && (slot_owner_q[i] == key_owner);
		end
	end

	// Max tree over the matching levels
	always_comb begin
		for (int i = 0; i < TREE_N; i++) begin
			if (i < SLOT_COUNT) begin
				tree[TREE_N-1+i] = match[i] ? slot_level_q[i] : '0;
			end else begin
				tree[TREE_N-1+i] = '0;
			end
		end
		for (int k = TREE_N - 2; k >= 0; k--) begin
			tree[k] = (tree[2*k+1] > tree[2*k+2]) ? tree[2*k+1] : tree[2*k+2];
		end
	end

	// Lowest free slot, handle resolve, release mask and its size
	always_comb begin
		free_found_c = 1'b0;
		free_idx_c   = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!slot_used_q[i]) begin
				free_found_c = 1'b1;
				free_idx_c   = IDX_W'(i);
			end
		end
		hit_c = pop_data.idx_ok && slot_used_q[pop_data.idx]
			&& (slot_gen_q[pop_data.idx] == pop_data.gen);
		for (int i = 0; i < SLOT_COUNT; i++) begin
			mask_c[i] = (pop_data.op == OP_RELEASE_ALL) ? slot_used_q[i] : match[i];
		end
		freed_c = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			freed_c = freed_c + CNT_W'(mask_c[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1       <= pop_data;
			deep_s1       <= tree[0];
			free_found_s1 <= free_found_c;
			free_idx_s1   <= free_idx_c;
			hit_s1        <= hit_c;
			mask_s1       <= mask_c;
			freed_s1      <= freed_c;
		end
	end

	// Frame addresses of the selected slot
	assign idx_c      = (item_s1.op == OP_ACQUIRE) ? free_idx_s1 : item_s1.idx;
	assign prod_c     = (IDX_W+STRIDE_W)'(idx_c) * (IDX_W+STRIDE_W)'(cfg.slot_stride);
	assign base_c     = cfg.region_base + ADDR_W'(prod_c);
	assign new_depth  = {1'b0, deep_s1} + 1'b1;
	assign depth_fits = (new_depth <= {1'b0, cfg.depth_limit});
	assign gen_inc    = slot_gen_q[free_idx_s1] + 1'b1;

	// Next table state and response
	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			used_n[i]  = slot_used_q[i];
			owner_n[i] = slot_owner_q[i];
			level_n[i] = slot_level_q[i];
			gen_n[i]   = slot_gen_q[i];
		end
		live_n    = live_q;
		exhaust_n = exhaust_q;
		lifo_n    = lifo_q;
		rsp_d     = '0;
		case (item_s1.op)
			OP_ACQUIRE: begin
				if (cfg.region_enable) begin
					if (!depth_fits || !free_found_s1) begin
						exhaust_n = exhaust_q + 1'b1;
					end else begin
						used_n[free_idx_s1]  = 1'b1;
						owner_n[free_idx_s1] = item_s1.owner_id;
						level_n[free_idx_s1] = new_depth[LVL_W-1:0];
						gen_n[free_idx_s1]   = gen_inc;
						live_n               = live_q + 1'b1;
						rsp_d.ok             = 1'b1;
						rsp_d.frame_handle   = {gen_inc, HIDX_W'(free_idx_s1)};
						rsp_d.frame_sp       = base_c + ADDR_W'(cfg.stack_offset);
						rsp_d.frame_owner    = item_s1.owner_id;
						rsp_d.frame_depth    = new_depth[LVL_W-1:0];
						rsp_d.frame_base     = base_c;
						rsp_d.frame_floor    = base_c + ADDR_W'(cfg.guard_bytes);
					end
				end
			end
			OP_RELEASE: begin
				if (hit_s1) begin
					if (slot_level_q[item_s1.idx] != deep_s1) begin
						lifo_n          = lifo_q + 1'b1;
						rsp_d.lifo_flag = 1'b1;
					end
					used_n[item_s1.idx]  = 1'b0;
					owner_n[item_s1.idx] = '0;
					level_n[item_s1.idx] = '0;
					live_n               = live_q - 1'b1;
					rsp_d.ok             = 1'b1;
				end
			end
			OP_RELEASE_OWNER, OP_RELEASE_ALL: begin
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (mask_s1[i]) begin
						used_n[i]  = 1'b0;
						owner_n[i] = '0;
						level_n[i] = '0;
					end
				end
				live_n            = live_q - freed_s1;
				rsp_d.ok          = 1'b1;
				rsp_d.freed_count = OCNT_W'(freed_s1);
			end
			OP_DEPTH_QUERY: begin
				rsp_d.ok          = 1'b1;
				rsp_d.frame_depth = deep_s1;
			end
			OP_HANDLE_INFO: begin
				if (hit_s1) begin
					rsp_d.ok          = 1'b1;
					rsp_d.frame_sp    = base_c + ADDR_W'(cfg.stack_offset);
					rsp_d.frame_owner = slot_owner_q[item_s1.idx];
					rsp_d.frame_depth = slot_level_q[item_s1.idx];
					rsp_d.frame_base  = base_c;
					rsp_d.frame_floor = base_c + ADDR_W'(cfg.guard_bytes);
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < SLOT_COUNT; i++) begin
					used_n[i]  = 1'b0;
					owner_n[i] = '0;
					level_n[i] = '0;
					gen_n[i]   = '0;
				end
				live_n    = '0;
				exhaust_n = '0;
				lifo_n    = '0;
				rsp_d.ok  = 1'b1;
			end
			default: begin
				rsp_d.ok = 1'b0;
			end
		endcase
		rsp_d.live_count    = OCNT_W'(live_n);
		rsp_d.exhaust_total = exhaust_n;
		rsp_d.lifo_total    = lifo_n;
	end

	// Update the table on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_used_q[i]  <= 1'b0;
				slot_owner_q[i] <= '0;
				slot_level_q[i] <= '0;
				slot_gen_q[i]   <= '0;
			end
			live_q    <= '0;
			exhaust_q <= '0;
			lifo_q    <= '0;
		end else if (commit_en) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_used_q[i]  <= used_n[i];
				slot_owner_q[i] <= owner_n[i];
				slot_level_q[i] <= level_n[i];
				slot_gen_q[i]   <= gen_n[i];
			end
			live_q    <= live_n;
			exhaust_q <= exhaust_n;
			lifo_q    <= lifo_n;
		end
	end

	// Hold the response until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit_en) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_en) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.ok            = rsp_q.ok;
	assign rsp.frame_handle  = rsp_q.frame_handle;
	assign rsp.frame_sp      = rsp_q.frame_sp;
	assign rsp.frame_owner   = rsp_q.frame_owner;
	assign rsp.frame_depth   = rsp_q.frame_depth;
	assign rsp.frame_base    = rsp_q.frame_base;
	assign rsp.frame_floor   = rsp_q.frame_floor;
	assign rsp.freed_count   = rsp_q.freed_count;
	assign rsp.lifo_flag     = rsp_q.lifo_flag;
	assign rsp.live_count    = rsp_q.live_count;
	assign rsp.exhaust_total = rsp_q.exhaust_total;
	assign rsp.lifo_total    = rsp_q.lifo_total;

endmodule

// File: design/nested_frame_slot_allocator.sv
// Top level of the nested frame slot allocator: configuration registers and block wiring.
//
//   channel | dir | handshake            | carries
//   --------+-----+----------------------+------------------------------------------
//   req     | in  | valid/ready          | func, owner_id, handle_in
//   rsp     | out | valid/ready          | ok, frame fields, counts and totals
//   apb     | in  | psel/penable/pready  | six configuration registers at 4*i
//
// Each request passes the back end in order: a scan of the slot table (owner depth
// tree, lowest free slot, handle check) into registers, then a commit of the table
// update that loads the response register; no new item is taken until the last one commits.
// A two-entry queue lets the front accept while the back end works or waits.
// A stalled response holds the commit; reset clears the table, counters and queue.
module nested_frame_slot_allocator import nfsa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	nfsa_req_if.sink           req,
	nfsa_rsp_if.source         rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t             cfg_q;
	logic [RSEL_W-1:0] rsel;
	logic             cfg_wr;

	logic     push_valid;
	logic     push_ready;
	q_entry_t push_data;
	logic     pop_valid;
	logic     pop_ready;
	q_entry_t pop_data;

	assign pready = 1'b1;
	assign rsel   = paddr[PADDR_W-1:2];
	assign cfg_wr = psel && penable && pwrite && pready;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.region_base   <= RST_REGION_BASE;
			cfg_q.slot_stride   <= RST_SLOT_STRIDE;
			cfg_q.stack_offset  <= RST_STACK_OFFSET;
			cfg_q.guard_bytes   <= RST_GUARD_BYTES;
			cfg_q.depth_limit   <= RST_DEPTH_LIMIT;
			cfg_q.region_enable <= 1'b0;
		end else if (cfg_wr) begin
			case (rsel)
				REG_REGION_BASE:   cfg_q.region_base   <= pwdata;
				REG_SLOT_STRIDE:   cfg_q.slot_stride   <= pwdata[STRIDE_W-1:0];
				REG_STACK_OFFSET:  cfg_q.stack_offset  <= pwdata[OFS_W-1:0];
				REG_GUARD_BYTES:   cfg_q.guard_bytes   <= pwdata[OFS_W-1:0];
				REG_DEPTH_LIMIT:   cfg_q.depth_limit   <= pwdata[LVL_W-1:0];
				REG_REGION_ENABLE: cfg_q.region_enable <= pwdata[0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		case (rsel)
			REG_REGION_BASE:   prdata = cfg_q.region_base;
			REG_SLOT_STRIDE:   prdata = PDATA_W'(cfg_q.slot_stride);
			REG_STACK_OFFSET:  prdata = PDATA_W'(cfg_q.stack_offset);
			REG_GUARD_BYTES:   prdata = PDATA_W'(cfg_q.guard_bytes);
			REG_DEPTH_LIMIT:   prdata = PDATA_W'(cfg_q.depth_limit);
			REG_REGION_ENABLE: prdata = PDATA_W'(cfg_q.region_enable);
			default:           prdata = '0;
		endcase
	end

	nfsa_front u_front (
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	nfsa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	nfsa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.rsp       (rsp)
	);

endmodule

// File: test/nfsa_response_checker.sv
// Response checker for the frame slot allocator: follows register writes, predicts, compares.
module nfsa_response_checker import nfsa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	nfsa_req_if                req,
	nfsa_rsp_if                rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output int                 mismatch_count,
	output int                 awaited_count,
	output int                 compared_count
);
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow of the configuration and of the slot table
	cfg_t               regs;
	logic               slot_busy   [SLOT_COUNT];
	logic [ID_W-1:0]    slot_holder [SLOT_COUNT];
	logic [LVL_W-1:0]   slot_depth  [SLOT_COUNT];
	logic [GEN_W-1:0]   slot_epoch  [SLOT_COUNT];
	logic [OCNT_W-1:0]  frames_live;
	logic [TOTAL_W-1:0] refused_total;
	logic [TOTAL_W-1:0] misorder_total;
	rsp_t               awaited_results [$];

	// Drop every frame, generations and counters included
	function automatic void wipe_table();
		for (int i = 0; i < SLOT_COUNT; i++) begin
			slot_busy[i]   = 1'b0;
			slot_holder[i] = '0;
			slot_depth[i]  = '0;
			slot_epoch[i]  = '0;
		end
		frames_live    = '0;
		refused_total  = '0;
		misorder_total = '0;
	endfunction

	// Deepest nesting level held by one owner, zero when it holds nothing
	function automatic int deepest_frame(input logic [ID_W-1:0] who);
		int d;
		d = 0;
		for (int i = 0; i < SLOT_COUNT; i++)
			if (slot_busy[i] && slot_holder[i] == who && int'(slot_depth[i]) > d)
				d = int'(slot_depth[i]);
		return d;
	endfunction

	// Slot named by a handle, or -1 when out of range, free or of another generation
	function automatic int lookup_handle(input logic [HANDLE_W-1:0] h);
		int i;
		i = int'(h[HIDX_W-1:0]);
		if (i >= SLOT_COUNT || !slot_busy[i]) return -1;
		if (h[HANDLE_W-1:HIDX_W] != slot_epoch[i]) return -1;
		return i;
	endfunction

	function automatic void release_slot(input int i);
		slot_busy[i]   = 1'b0;
		slot_holder[i] = '0;
		slot_depth[i]  = '0;
		if (frames_live != 0) frames_live--;
	endfunction

	// Address fields of one frame, all modulo 2^32
	function automatic void fill_frame(inout rsp_t r, input int i);
		logic [ADDR_W-1:0] base;
		base          = regs.region_base + ADDR_W'(i) * ADDR_W'(regs.slot_stride);
		r.frame_sp    = base + ADDR_W'(regs.stack_offset);
		r.frame_owner = slot_holder[i];
		r.frame_depth = slot_depth[i];
		r.frame_base  = base;
		r.frame_floor = base + ADDR_W'(regs.guard_bytes);
	endfunction

	// Apply one request to the shadow table and return the response it should give
	function automatic rsp_t predict_frame_result(input logic [FUNC_W-1:0] func,
		input logic [ID_W-1:0] who, input logic [HANDLE_W-1:0] h);
		rsp_t r;
		int   d;
		int   i;
		int   n;
		r = '0;
		case (func)
			FUNC_ACQUIRE: begin
				if (regs.region_enable) begin
					d = deepest_frame(who) + 1;
					i = 0;
					while (i < SLOT_COUNT && slot_busy[i]) i++;
					if (d > int'(regs.depth_limit) || i >= SLOT_COUNT) begin
						refused_total++;
					end else begin
						slot_busy[i]   = 1'b1;
						slot_holder[i] = who;
						slot_depth[i]  = LVL_W'(d);
						slot_epoch[i]  = slot_epoch[i] + 1'b1;
						frames_live++;
						r.ok           = 1'b1;
						r.frame_handle = {slot_epoch[i], HIDX_W'(i)};
						fill_frame(r, i);
					end
				end
			end
			FUNC_RELEASE: begin
				i = lookup_handle(h);
				if (i >= 0) begin
					// flag a frame freed while a deeper one of its owner lives
					if (int'(slot_depth[i]) != deepest_frame(slot_holder[i])) begin
						misorder_total++;
						r.lifo_flag = 1'b1;
					end
					release_slot(i);
					r.ok = 1'b1;
				end
			end
			FUNC_RELEASE_OWNER, FUNC_RELEASE_ALL: begin
				n = 0;
				for (int s = 0; s < SLOT_COUNT; s++)
					if (slot_busy[s] && (func == FUNC_RELEASE_ALL || slot_holder[s] == who)) begin
						release_slot(s);
						n++;
					end
				r.ok          = 1'b1;
				r.freed_count = OCNT_W'(n);
			end
			FUNC_DEPTH_QUERY: begin
				r.ok          = 1'b1;
				r.frame_depth = LVL_W'(deepest_frame(who));
			end
			FUNC_HANDLE_INFO: begin
				i = lookup_handle(h);
				if (i >= 0) begin
					r.ok = 1'b1;
					fill_frame(r, i);
				end
			end
			FUNC_CLEAR: begin
				wipe_table();
				r.ok = 1'b1;
			end
			default: ;
		endcase
		r.live_count    = frames_live;
		r.exhaust_total = refused_total;
		r.lifo_total    = misorder_total;
		return r;
	endfunction

	function automatic void write_register(input logic [RSEL_W-1:0] sel,
		input logic [PDATA_W-1:0] v);
		case (sel)
			REG_REGION_BASE:   regs.region_base   = v;
			REG_SLOT_STRIDE:   regs.slot_stride   = v[STRIDE_W-1:0];
			REG_STACK_OFFSET:  regs.stack_offset  = v[OFS_W-1:0];
			REG_GUARD_BYTES:   regs.guard_bytes   = v[OFS_W-1:0];
			REG_DEPTH_LIMIT:   regs.depth_limit   = v[LVL_W-1:0];
			REG_REGION_ENABLE: regs.region_enable = v[0];
			default: ;
		endcase
	endfunction

	function automatic void compare_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("response %0d, %s: expected 0x%0h, got 0x%0h",
					compared_count, name, want, got);
		end
	endfunction

	// Track writes, predict accepted requests, compare accepted responses in order
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			regs.region_base   = RST_REGION_BASE;
			regs.slot_stride   = RST_SLOT_STRIDE;
			regs.stack_offset  = RST_STACK_OFFSET;
			regs.guard_bytes   = RST_GUARD_BYTES;
			regs.depth_limit   = RST_DEPTH_LIMIT;
			regs.region_enable = 1'b0;
			wipe_table();
			awaited_results.delete();
			mismatch_count = 0;
			compared_count = 0;
		end else begin
			if (psel && penable && pwrite && pready)
				write_register(paddr[PADDR_W-1:2], pwdata);
			if (req.valid && req.ready)
				awaited_results.push_back(
					predict_frame_result(req.func, req.owner_id, req.handle_in));
			if (rsp.valid && rsp.ready) begin
				if (awaited_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("response arrived with no request outstanding");
				end else begin
					want = awaited_results.pop_front();
					compare_field("ok", 64'(want.ok), 64'(rsp.ok));
					compare_field("frame_handle", 64'(want.frame_handle),
						64'(rsp.frame_handle));
					compare_field("frame_sp", 64'(want.frame_sp), 64'(rsp.frame_sp));
					compare_field("frame_owner", 64'(want.frame_owner),
						64'(rsp.frame_owner));
					compare_field("frame_depth", 64'(want.frame_depth),
						64'(rsp.frame_depth));
					compare_field("frame_base", 64'(want.frame_base), 64'(rsp.frame_base));
					compare_field("frame_floor", 64'(want.frame_floor),
						64'(rsp.frame_floor));
					compare_field("freed_count", 64'(want.freed_count),
						64'(rsp.freed_count));
					compare_field("lifo_flag", 64'(want.lifo_flag), 64'(rsp.lifo_flag));
					compare_field("live_count", 64'(want.live_count), 64'(rsp.live_count));
					compare_field("exhaust_total", 64'(want.exhaust_total),
						64'(rsp.exhaust_total));
					compare_field("lifo_total", 64'(want.lifo_total), 64'(rsp.lifo_total));
					compared_count++;
				end
			end
		end
		awaited_count = awaited_results.size();
	end

endmodule

// File: test/nested_frame_slot_allocator_test.sv
// Testbench top of the frame slot allocator: clock, reset, stimulus and verdict.
module nested_frame_slot_allocator_test import nfsa_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LONG_HOLD   = 400;
	localparam int TAIL_CYCLES = 20;
	localparam int HANDLE_KEEP = 24;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int mismatch_count;
	int awaited_count;
	int compared_count;
	int items_sent;
	int settings_used;
	bit steady;
	bit hold_request;

	logic [HANDLE_W-1:0] issued_handles [$];
	logic [ID_W-1:0]     owner_set [5] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
		32'hA5A5_5A5A, 32'h8000_0000};

	nfsa_req_if req_ch();
	nfsa_rsp_if rsp_ch();

	nested_frame_slot_allocator DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	nfsa_response_checker result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.mismatch_count (mismatch_count),
		.awaited_count  (awaited_count),
		.compared_count (compared_count)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Keep the most recent handles issued so releases can name live frames
	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready && rsp_ch.ok && rsp_ch.frame_handle != '0) begin
			issued_handles.push_back(rsp_ch.frame_handle);
			if (issued_handles.size() > HANDLE_KEEP) void'(issued_handles.pop_front());
		end
	end

	// Response side: random backpressure, or one long hold when requested
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				rsp_ch.ready <= steady || ($urandom_range(99) >= 13);
			end
		end
	end

	// Offer one request, with a random idle gap first, and hold it until accepted
	task automatic offer(input logic [FUNC_W-1:0] func, input logic [ID_W-1:0] who,
		input logic [HANDLE_W-1:0] h);
		while (!steady && $urandom_range(99) < 13) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.func      <= func;
		req_ch.owner_id  <= who;
		req_ch.handle_in <= h;
		@(posedge clk);
		while (req_ch.ready !== 1'b1) @(posedge clk);
		items_sent++;
	endtask

	// Stop offering and wait until every response is back
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (awaited_count != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// Setup cycle, access cycle, then release the bus
	task automatic write_reg(input logic [RSEL_W-1:0] sel, input logic [PDATA_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_region(input logic [PDATA_W-1:0] base, input logic [PDATA_W-1:0] stride,
		input logic [PDATA_W-1:0] ofs, input logic [PDATA_W-1:0] guard,
		input logic [PDATA_W-1:0] limit, input logic [PDATA_W-1:0] en);
		write_reg(REG_REGION_BASE, base);
		write_reg(REG_SLOT_STRIDE, stride);
		write_reg(REG_STACK_OFFSET, ofs);
		write_reg(REG_GUARD_BYTES, guard);
		write_reg(REG_DEPTH_LIMIT, limit);
		write_reg(REG_REGION_ENABLE, en);
		settings_used++;
	endtask

	// Mostly a few recurring owners so frames nest and collide
	function automatic logic [ID_W-1:0] pick_owner();
		if ($urandom_range(99) < 80) return owner_set[$urandom_range(4)];
		return $urandom;
	endfunction

	// Mostly real handles, some with a bad generation, out of range or pure noise
	function automatic logic [HANDLE_W-1:0] pick_handle();
		logic [HANDLE_W-1:0] h;
		int                  r;
		r = $urandom_range(99);
		h = HANDLE_W'($urandom);
		if (r < 75 && issued_handles.size() != 0) begin
			h = issued_handles[$urandom_range(issued_handles.size() - 1)];
			if (r >= 65) h[HIDX_W + $urandom_range(GEN_W - 1)] ^= 1'b1;
		end else if (r < 87) begin
			h[HIDX_W-1:0] = HIDX_W'($urandom_range(31, SLOT_COUNT));
		end
		return h;
	endfunction

	task automatic random_op();
		int r;
		r = $urandom_range(99);
		if (r < 38)      offer(FUNC_ACQUIRE, pick_owner(), HANDLE_W'($urandom));
		else if (r < 64) offer(FUNC_RELEASE, $urandom, pick_handle());
		else if (r < 70) offer(FUNC_RELEASE_OWNER, pick_owner(), HANDLE_W'($urandom));
		else if (r < 72) offer(FUNC_RELEASE_ALL, $urandom, HANDLE_W'($urandom));
		else if (r < 80) offer(FUNC_DEPTH_QUERY, pick_owner(), HANDLE_W'($urandom));
		else if (r < 95) offer(FUNC_HANDLE_INFO, $urandom, pick_handle());
		else if (r < 97) offer(FUNC_CLEAR, $urandom, HANDLE_W'($urandom));
		else             offer(FUNC_W'(OP_NONE), $urandom, HANDLE_W'($urandom));
	endtask

	task automatic run_phase(input int count);
		for (int n = 0; n < count; n++) random_op();
		drain();
	endtask

	// Stimulus: directed opening, then random phases under several settings
	initial begin
		logic [HANDLE_W-1:0] outer_h;
		logic [HANDLE_W-1:0] middle_h;
		logic [HANDLE_W-1:0] inner_h;
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		req_ch.valid     = 1'b0;
		req_ch.func      = FUNC_ACQUIRE;
		req_ch.owner_id  = '0;
		req_ch.handle_in = '0;
		steady           = 1'b0;
		hold_request     = 1'b0;
		items_sent       = 0;
		settings_used    = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// region still disabled after reset, then an undefined function
		offer(FUNC_ACQUIRE, '0, '0);
		offer(FUNC_W'(OP_NONE), '1, '1);
		drain();

		// nest three frames for one owner; the fourth exceeds the depth limit
		program_region(32'h4000_0000, 4096, 3072, 256, 3, 1);
		repeat (4) offer(FUNC_ACQUIRE, '1, '0);
		offer(FUNC_DEPTH_QUERY, '1, '0);
		offer(FUNC_DEPTH_QUERY, '0, '0);
		drain();
		outer_h  = issued_handles[0];
		middle_h = issued_handles[1];
		inner_h  = issued_handles[2];

		// out of order release, double release, stale and out of range handles
		offer(FUNC_RELEASE, '0, outer_h);
		offer(FUNC_RELEASE, '0, outer_h);
		offer(FUNC_HANDLE_INFO, '0, inner_h);
		offer(FUNC_HANDLE_INFO, '0, inner_h ^ HANDLE_W'(1 << HIDX_W));
		offer(FUNC_RELEASE, '0, '1);
		offer(FUNC_RELEASE, '0, inner_h);
		offer(FUNC_RELEASE_OWNER, '1, '0);
		offer(FUNC_ACQUIRE, '0, '0);
		offer(FUNC_ACQUIRE, 32'h1, '0);
		offer(FUNC_RELEASE_ALL, '0, '0);
		offer(FUNC_HANDLE_INFO, '0, middle_h);
		offer(FUNC_ACQUIRE, 32'h1, '0);
		offer(FUNC_CLEAR, '0, '0);
		offer(FUNC_DEPTH_QUERY, 32'h1, '0);
		drain();

		// random phases
		program_region(32'h1000_0000, 4096, 3072, 256, 4, 1);
		run_phase(350);

		// address wrap, widest fields, deep nesting, and a long response hold
		program_region(32'hFFFF_F000, 65536, 65535, 65535, 31, 1);
		hold_request = 1'b1;
		run_phase(350);

		// narrowest settings with no idling on either side
		program_region(32'h0000_0000, 16, 0, 0, 1, 1);
		steady = 1'b1;
		run_phase(350);
		steady = 1'b0;

		program_region($urandom, $urandom_range(65536, 16), $urandom_range(65535),
			$urandom_range(65535), $urandom_range(8, 2), 1);
		run_phase(300);

		// zero depth limit, then a disabled region
		program_region($urandom, 4096, 3072, 256, 0, 1);
		run_phase(80);
		program_region($urandom, 4096, 3072, 256, 3, 0);
		run_phase(80);

		program_region($urandom, $urandom_range(65536, 16), $urandom_range(65535),
			$urandom_range(65535), $urandom_range(8, 2), 1);
		run_phase(300);

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d requests under %0d register settings, %0d responses compared.",
			items_sent, settings_used, compared_count);
		$display("Ran with disabled region, zero and full depth limits, address wrap, long stall.");
		if (mismatch_count == 0 && awaited_count == 0) begin
			$display("PASS nested_frame_slot_allocator");
		end else begin
			$display("FAIL nested_frame_slot_allocator");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#400_000;
		$display("FAIL nested_frame_slot_allocator");
		$finish;
	end

endmodule

// File: files.f
design/nfsa_pkg.sv
design/nfsa_ifs.sv
design/nfsa_front.sv
design/nfsa_queue.sv
design/nfsa_back.sv
design/nested_frame_slot_allocator.sv
test/nfsa_response_checker.sv
test/nested_frame_slot_allocator_test.sv
